### hw/rtl/bsst_pkg.sv
// Shared types and constants of the bead swing signal self-test core.
package bsst_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = 10;
  localparam int ERR_W    = 4;
  localparam int RUN_W    = 2;
  localparam int IDX_W    = 3;

  localparam logic [PEAK_W-1:0]   MIN_PEAKS = PEAK_W'(4);
  localparam logic [PEAK_W-1:0]   PEAK_SAT  = {PEAK_W{1'b1}};
  localparam logic [ERR_W-1:0]    ERR_SAT   = {ERR_W{1'b1}};
  localparam logic [RUN_W-1:0]    RUN_SAT   = {RUN_W{1'b1}};

  localparam logic [SAMPLE_W-1:0] LOW_LEVEL_RST     = SAMPLE_W'(10);
  localparam logic [SAMPLE_W-1:0] PEAK_MIN_RST      = SAMPLE_W'(1800);
  localparam logic [SAMPLE_W-1:0] PEAK_DIFF_MAX_RST = SAMPLE_W'(1000);
  localparam logic [SAMPLE_W-1:0] NOISE_LEVEL_RST   = SAMPLE_W'(200);
  localparam logic [ERR_W-1:0]    ERROR_LIMIT_RST   = ERR_W'(3);

  typedef enum logic [IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_LOW_LEVEL     = 3'd1,
    REG_PEAK_MIN      = 3'd2,
    REG_PEAK_DIFF_MAX = 3'd3,
    REG_NOISE_LEVEL   = 3'd4,
    REG_ERROR_LIMIT   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    MODE_NOISE = 1'b0,
    MODE_SWING = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [SAMPLE_W-1:0] low_level;
    logic [SAMPLE_W-1:0] peak_min;
    logic [SAMPLE_W-1:0] peak_diff_max;
    logic [SAMPLE_W-1:0] noise_level;
    logic [ERR_W-1:0]    error_limit;
  } cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0]  fault_total;
    logic [PEAK_W-1:0] peak_total;
    logic              fail;
  } result_t;

endpackage

### hw/rtl/bsst_cfg.sv
// Configuration register file of the self-test core.
module bsst_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bsst_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bsst_pkg::SAMPLE_W-1:0]     cfg_data,
  output bsst_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= bsst_pkg::MODE_NOISE;
      cfg.low_level     <= bsst_pkg::LOW_LEVEL_RST;
      cfg.peak_min      <= bsst_pkg::PEAK_MIN_RST;
      cfg.peak_diff_max <= bsst_pkg::PEAK_DIFF_MAX_RST;
      cfg.noise_level   <= bsst_pkg::NOISE_LEVEL_RST;
      cfg.error_limit   <= bsst_pkg::ERROR_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsst_pkg::REG_MODE:          cfg.mode          <= bsst_pkg::mode_t'(cfg_data[0]);
        bsst_pkg::REG_LOW_LEVEL:     cfg.low_level     <= cfg_data;
        bsst_pkg::REG_PEAK_MIN:      cfg.peak_min      <= cfg_data;
        bsst_pkg::REG_PEAK_DIFF_MAX: cfg.peak_diff_max <= cfg_data;
        bsst_pkg::REG_NOISE_LEVEL:   cfg.noise_level   <= cfg_data;
        bsst_pkg::REG_ERROR_LIMIT:   cfg.error_limit   <= cfg_data[bsst_pkg::ERR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/bsst_eval.sv
// Per-sample record state update and end-of-record verdict.
module bsst_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  logic [bsst_pkg::SAMPLE_W-1:0] sample,
  input  logic                          last,
  input  bsst_pkg::cfg_t                cfg,
  output bsst_pkg::result_t             res
);

  logic [bsst_pkg::RUN_W-1:0]    low_run,       low_run_next;
  logic                          armed,         armed_next;
  logic                          in_peak,       in_peak_next;
  logic                          first_pending;
  logic [bsst_pkg::SAMPLE_W-1:0] running_max,   running_max_next;
  logic [bsst_pkg::SAMPLE_W-1:0] previous_peak, previous_peak_next;
  logic [bsst_pkg::PEAK_W-1:0]   peak_count,    peak_count_next;
  logic [bsst_pkg::ERR_W-1:0]    fault_count,   fault_count_next;

  logic                          low;
  logic                          armed_now;
  logic [bsst_pkg::SAMPLE_W-1:0] diff;
  logic [1:0]                    err_add;
  logic [bsst_pkg::ERR_W:0]      err_sum;

  always_comb begin
    low                = (sample <= cfg.low_level);
    low_run_next       = low_run;
    armed_next         = armed;
    in_peak_next       = in_peak;
    running_max_next   = running_max;
    previous_peak_next = previous_peak;
    peak_count_next    = peak_count;
    err_add            = 2'd0;
    armed_now          = armed;
    diff = (previous_peak > running_max) ? previous_peak - running_max
                                         : running_max - previous_peak;

    if (cfg.mode == bsst_pkg::MODE_NOISE) begin
      err_add = {1'b0, sample > cfg.noise_level};
    end else begin
      if (low) begin
        low_run_next = (low_run == bsst_pkg::RUN_SAT) ? low_run : low_run + 1'b1;
      end else begin
        low_run_next = '0;
      end
      armed_now  = armed | (low_run_next > 2'd1) | first_pending;
      armed_next = armed_now;

      if (armed_now && !low && !in_peak) begin
        in_peak_next     = 1'b1;
        armed_next       = 1'b0;
        running_max_next = sample;
      end else if (armed_now && low && in_peak) begin
        // peak closes; pairs are judged from the third peak on
        if (peak_count >= bsst_pkg::PEAK_W'(2)) begin
          err_add = 2'(previous_peak < cfg.peak_min && running_max < cfg.peak_min)
                  + 2'(diff > cfg.peak_diff_max);
        end
        previous_peak_next = running_max;
        peak_count_next    = (peak_count == bsst_pkg::PEAK_SAT) ? peak_count
                                                                 : peak_count + 1'b1;
        in_peak_next       = 1'b0;
        armed_next         = 1'b0;
        running_max_next   = '0;
      end else if (in_peak && sample > running_max) begin
        running_max_next = sample;
      end
    end

    err_sum = {1'b0, fault_count} + {3'b000, err_add};
    fault_count_next = (err_sum > {1'b0, bsst_pkg::ERR_SAT}) ? bsst_pkg::ERR_SAT
                                                             : err_sum[bsst_pkg::ERR_W-1:0];

    res.fault_total = fault_count_next;
    if (cfg.mode == bsst_pkg::MODE_NOISE) begin
      res.peak_total = '0;
      res.fail       = (fault_count_next > cfg.error_limit);
    end else begin
      res.peak_total = peak_count_next;
      res.fail       = (peak_count_next <= bsst_pkg::MIN_PEAKS) ||
                       (fault_count_next > cfg.error_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (commit && last)) begin
      low_run       <= '0;
      armed         <= 1'b0;
      in_peak       <= 1'b0;
      first_pending <= 1'b1;
      running_max   <= '0;
      previous_peak <= '0;
      peak_count    <= '0;
      fault_count   <= '0;
    end else if (commit) begin
      low_run       <= low_run_next;
      armed         <= armed_next;
      in_peak       <= in_peak_next;
      first_pending <= 1'b0;
      running_max   <= running_max_next;
      previous_peak <= previous_peak_next;
      peak_count    <= peak_count_next;
      fault_count   <= fault_count_next;
    end
  end

endmodule

### hw/rtl/bead_swing_signal_self_test_core.sv
// Top level of the bead swing signal self-test core.
// Checks one channel's sample record, one sample per request on the slave
// stream, tlast on the final sample. Mode 0 counts samples above the noise
// level; mode 1 segments the record into peaks and judges neighboring peak
// pairs. One result (fail, peak total, fault total) leaves on the master
// stream after the last sample. A sample passes an input register and then
// the compare and counter logic, so one sample is taken every cycle while
// input is not held; the result is written to the output register when
// its last sample leaves the input register. Input is held only while a
// finished result waits in the output register and another last sample
// is ready to finish. Configuration writes are taken at any time, one per
// cycle, and belong between records.
module bead_swing_signal_self_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] fail, [10:1] peak_total, [14:11] fault_total
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bsst_pkg::cfg_t    cfg;
  bsst_pkg::result_t res;

  logic                          stg_valid;
  logic [bsst_pkg::SAMPLE_W-1:0] stg_sample;
  logic                          stg_last;
  logic                          out_free;
  logic                          commit;
  bsst_pkg::result_t             out_res;

  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign commit        = stg_valid && (!stg_last || out_free);
  assign s_axis_tready = !stg_valid || commit;
  assign m_axis_tdata  = {1'b0, out_res};

  bsst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bsst_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .sample (stg_sample),
    .last   (stg_last),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stg_sample <= s_axis_tdata;
      stg_last   <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit && stg_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && stg_last) begin
      out_res <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(commit && stg_last))
    else $error("result appeared without a finished record");

  a_noise_no_peaks: assert property (@(posedge clk) disable iff (rst)
    (commit && stg_last && cfg.mode == bsst_pkg::MODE_NOISE) |=> m_axis_tdata[10:1] == 10'd0)
    else $error("noise mode result carries peaks");

  a_few_peaks_fail: assert property (@(posedge clk) disable iff (rst)
    (commit && stg_last && cfg.mode == bsst_pkg::MODE_SWING &&
     res.peak_total <= bsst_pkg::MIN_PEAKS) |=> m_axis_tdata[0])
    else $error("too few peaks but record passed");

  a_stall_needs_data: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (stg_valid && stg_last && m_axis_tvalid))
    else $error("input stalled without a pending result");
`endif

endmodule

### tb/bead_swing_signal_self_test_core_test.sv
// Self-checking testbench for the bead swing signal self-test core.
`timescale 1ns / 1ps

module bead_swing_signal_self_test_core_test;
  import bsst_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_SAMPLES = 600;
  localparam int DRAIN_CYCLES   = 4;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  bead_swing_signal_self_test_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // register copy and record state of the verdict predictor
  cfg_t              cfg_copy;
  logic [RUN_W-1:0]  lows_seen;
  logic              armed;
  logic              inside_peak;
  logic              record_start;
  logic [15:0]       peak_top;
  logic [15:0]       last_peak;
  logic [PEAK_W-1:0] peaks_closed;
  logic [ERR_W-1:0]  faults;

  result_t     pending_verdicts[$];
  logic [15:0] wave[$];

  int idle_pct        = 0;
  int ready_hold      = 0;
  int mismatches      = 0;
  int samples_sent    = 0;
  int records_sent    = 0;
  int verdicts_seen   = 0;
  int swing_records   = 0;
  int config_phases   = 0;

  function automatic int pick_gap();
    if ($urandom_range(99, 0) >= idle_pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic void clear_record();
    lows_seen    = '0;
    armed        = 1'b0;
    inside_peak  = 1'b0;
    record_start = 1'b1;
    peak_top     = '0;
    last_peak    = '0;
    peaks_closed = '0;
    faults       = '0;
  endfunction

  function automatic void bump_fault();
    if (faults != ERR_SAT) faults++;
  endfunction

  task automatic score_sample(input logic [15:0] value, input logic is_last);
    logic        is_low;
    logic [15:0] spread;
    result_t     verdict;
    if (cfg_copy.mode == MODE_NOISE) begin
      if (value > cfg_copy.noise_level) bump_fault();
    end else begin
      is_low = (value <= cfg_copy.low_level);
      if (is_low) begin
        if (lows_seen != RUN_SAT) lows_seen++;
      end else begin
        lows_seen = '0;
      end
      if (lows_seen > 2'd1 || record_start) armed = 1'b1;
      if (armed && !is_low && !inside_peak) begin
        inside_peak = 1'b1;
        armed       = 1'b0;
        peak_top    = value;
      end else if (armed && is_low && inside_peak) begin
        // the pair of the first two peaks is exempt
        if (peaks_closed >= PEAK_W'(2)) begin
          spread = (last_peak > peak_top) ? last_peak - peak_top : peak_top - last_peak;
          if (last_peak < cfg_copy.peak_min && peak_top < cfg_copy.peak_min) bump_fault();
          if (spread > cfg_copy.peak_diff_max) bump_fault();
        end
        last_peak = peak_top;
        if (peaks_closed != PEAK_SAT) peaks_closed++;
        inside_peak = 1'b0;
        armed       = 1'b0;
        peak_top    = '0;
      end else if (inside_peak && value > peak_top) begin
        peak_top = value;
      end
    end
    record_start = 1'b0;
    if (is_last) begin
      if (cfg_copy.mode == MODE_NOISE) begin
        verdict.fail       = (faults > cfg_copy.error_limit);
        verdict.peak_total = '0;
      end else begin
        verdict.fail       = (peaks_closed <= MIN_PEAKS) || (faults > cfg_copy.error_limit);
        verdict.peak_total = peaks_closed;
        swing_records++;
      end
      verdict.fault_total = faults;
      pending_verdicts.push_back(verdict);
      records_sent++;
      clear_record();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_sample(input logic [15:0] value, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    score_sample(value, is_last);
    samples_sent++;
  endtask

  task automatic play_wave();
    for (int k = 0; k < wave.size(); k++) send_sample(wave[k], k == wave.size() - 1);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:          cfg_copy.mode          = mode_t'(value[0]);
      REG_LOW_LEVEL:     cfg_copy.low_level     = value;
      REG_PEAK_MIN:      cfg_copy.peak_min      = value;
      REG_PEAK_DIFF_MAX: cfg_copy.peak_diff_max = value;
      REG_NOISE_LEVEL:   cfg_copy.noise_level   = value;
      REG_ERROR_LIMIT:   cfg_copy.error_limit   = value[ERR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop the sample stream and let every pending verdict drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] swing_low();
    return 16'($urandom_range(int'(cfg_copy.low_level), 0));
  endfunction

  function automatic logic [15:0] swing_high();
    int v;
    if ($urandom_range(2, 0) == 0) v = $urandom_range(65535, 0);
    else v = int'(cfg_copy.peak_min) + int'($urandom_range(2400, 0)) - 1200;
    if (v <= int'(cfg_copy.low_level)) v = int'(cfg_copy.low_level) + 1 + $urandom_range(50, 0);
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_threshold(input int typical);
    case ($urandom_range(7, 0))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(typical, 0));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      ready_hold = pick_gap();
      m_axis_tready <= (ready_hold == 0);
      if (ready_hold != 0) ready_hold--;
    end
  end

  always @(posedge clk) begin : verdict_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict, tdata", int'(m_axis_tdata), 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.fail != want.fail)
          report_mismatch("fail", int'(got.fail), int'(want.fail));
        if (got.peak_total != want.peak_total)
          report_mismatch("peak_total", int'(got.peak_total), int'(want.peak_total));
        if (got.fault_total != want.fault_total)
          report_mismatch("fault_total", int'(got.fault_total), int'(want.fault_total));
      end
    end
  end

  task automatic test_noise_defaults();
    idle_pct = 0;
    wave = '{16'd200, 16'd201, 16'hFFFF, 16'd0};
    play_wave();
    wave = '{16'd0};
    play_wave();
    settle();
  endtask

  task automatic test_swing_directed();
    write_reg(REG_MODE, 16'hFFFF);          // only bit 0 counts
    write_reg(REG_LOW_LEVEL, LOW_LEVEL_RST);
    write_reg(REG_PEAK_MIN, PEAK_MIN_RST);
    write_reg(REG_PEAK_DIFF_MAX, PEAK_DIFF_MAX_RST);
    write_reg(REG_NOISE_LEVEL, NOISE_LEVEL_RST);
    write_reg(REG_ERROR_LIMIT, 16'hFFF3);   // upper bits dropped
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    idle_pct = 20;
    // opens on the very first sample, an unarmed high is skipped, low pair,
    // wide swing, spread right at the limit, unclosed peak at the end
    wave = '{16'd2500, 16'd3000, 16'd0, 16'd10, 16'd40000, 16'd0, 16'd0,
             16'd1000, 16'd0, 16'd0, 16'd0, 16'd1700, 16'd5, 16'd5,
             16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd64535, 16'd0, 16'd0,
             16'd0, 16'd7, 16'd20000};
    play_wave();
    wave = '{16'd40000};
    play_wave();
    settle();
  endtask

  task automatic test_long_record();
    write_reg(REG_LOW_LEVEL, 16'd100);
    write_reg(REG_PEAK_MIN, 16'hFFFF);
    write_reg(REG_PEAK_DIFF_MAX, 16'd0);
    write_reg(REG_ERROR_LIMIT, 16'd15);
    idle_pct = 5;
    // many peaks; pair faults run well past the fault counter range
    wave.delete();
    wave.push_back(16'd0);
    repeat (60) begin
      wave.push_back(16'($urandom_range(65535, 101)));
      repeat (3) wave.push_back(swing_low());
    end
    play_wave();
    settle();
  endtask

  task automatic test_random_records();
    int start_count;
    int phase_start;
    int peaks;
    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_SAMPLES) begin
      write_reg(REG_MODE, 16'($urandom()));
      write_reg(REG_LOW_LEVEL, pick_threshold(400));
      write_reg(REG_PEAK_MIN, pick_threshold(4000));
      write_reg(REG_PEAK_DIFF_MAX, pick_threshold(3000));
      write_reg(REG_NOISE_LEVEL, pick_threshold(3000));
      write_reg(REG_ERROR_LIMIT, 16'($urandom()));
      if ($urandom_range(3, 0) == 0)
        write_reg($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom()));
      case ($urandom_range(3, 0))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      config_phases++;
      phase_start = samples_sent;
      while (samples_sent - phase_start < 150 &&
             samples_sent - start_count < RANDOM_SAMPLES) begin
        wave.delete();
        if (cfg_copy.mode == MODE_NOISE) begin
          repeat ($urandom_range(30, 1)) begin
            case ($urandom_range(3, 0))
              0: wave.push_back(cfg_copy.noise_level);
              1: wave.push_back((cfg_copy.noise_level == 16'hFFFF) ? 16'hFFFF
                                                                  : cfg_copy.noise_level + 16'd1);
              2: wave.push_back(16'($urandom_range(int'(cfg_copy.noise_level), 0)));
              default: wave.push_back(16'($urandom()));
            endcase
          end
        end else if ($urandom_range(9, 0) < 8) begin
          if ($urandom_range(1, 0) == 1)
            repeat ($urandom_range(3, 1)) wave.push_back(swing_low());
          peaks = $urandom_range(9, 0);
          for (int p = 0; p < peaks; p++) begin
            repeat ($urandom_range(4, 1)) wave.push_back(swing_high());
            // two lows close a peak but leave the next high unarmed
            repeat (($urandom_range(9, 0) == 0) ? 2 : $urandom_range(4, 3))
              wave.push_back(swing_low());
          end
          if ($urandom_range(3, 0) == 0) wave.push_back(swing_high());
        end else begin
          repeat ($urandom_range(30, 1)) begin
            case ($urandom_range(2, 0))
              0: wave.push_back(swing_low());
              1: wave.push_back(swing_high());
              default: wave.push_back(16'($urandom()));
            endcase
          end
        end
        if (wave.size() == 0) wave.push_back(swing_low());
        play_wave();
      end
      settle();
    end
  endtask

  initial begin
    cfg_copy.mode          = MODE_NOISE;
    cfg_copy.low_level     = LOW_LEVEL_RST;
    cfg_copy.peak_min      = PEAK_MIN_RST;
    cfg_copy.peak_diff_max = PEAK_DIFF_MAX_RST;
    cfg_copy.noise_level   = NOISE_LEVEL_RST;
    cfg_copy.error_limit   = ERROR_LIMIT_RST;
    clear_record();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_noise_defaults();
    test_swing_directed();
    test_long_record();
    test_random_records();

    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch("verdicts never delivered", 0, pending_verdicts.size());

    $display("run covered %0d samples in %0d records (%0d peak-mode), %0d random phases",
             samples_sent, records_sent, swing_records, config_phases);
    $display("verdicts checked: %0d, mismatches: %0d", verdicts_seen, mismatches);
    if (mismatches == 0) begin
      $display("bead_swing_signal_self_test_core_test: PASS");
    end else begin
      $display("bead_swing_signal_self_test_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("run timed out with %0d verdicts pending", pending_verdicts.size());
    $display("bead_swing_signal_self_test_core_test: FAIL");
    $finish;
  end

endmodule
